[rtl/sfp_pkg.sv]
// Shared types and constants for the sensor frame parser.
package sfp_pkg;

	localparam int MAX_PAYLOAD = 32;
	localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
	localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
	localparam int BUF_AW      = ADDR_W + 1;
	localparam int CMDQ_DEPTH  = 2;
	localparam int OUT_DEPTH   = 4;
	localparam int OUT_AW      = $clog2(OUT_DEPTH);

	localparam logic [7:0] REG_HEADER_BYTE = 8'd0;
	localparam logic [7:0] REG_WANTED_MSG  = 8'd1;
	localparam logic [7:0] REG_RECORD_SIZE = 8'd2;

	typedef struct packed {
		logic [7:0]  rx_byte;
		logic [31:0] now_us;
	} sfp_in_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic [4:0]  byte_index;
		logic [31:0] frame_time;
		logic        last;
	} sfp_out_t;

	typedef struct packed {
		logic              en;
		logic [BUF_AW-1:0] addr;
		logic [7:0]        data;
	} sfp_wr_t;

	typedef struct packed {
		logic             bank;
		logic [31:0]      frame_time;
		logic [CNT_W-1:0] count;
	} sfp_cmd_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} sfp_rel_t;

endpackage

[rtl/sfp_front.sv]
// Front end: config registers, frame state machine, checksum and buffer writes.
module sfp_front import sfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  sfp_in_t     item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output sfp_wr_t     wr,
	output logic        cmd_push,
	output sfp_cmd_t    cmd,
	input  sfp_rel_t    rel
);

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_DEV  = 3'd1;
	localparam logic [2:0] PH_SYS  = 3'd2;
	localparam logic [2:0] PH_MSG  = 3'd3;
	localparam logic [2:0] PH_SEQ  = 3'd4;
	localparam logic [2:0] PH_LEN  = 3'd5;
	localparam logic [2:0] PH_DATA = 3'd6;
	localparam logic [2:0] PH_SUM  = 3'd7;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);

	logic [7:0]       header_q;
	logic [7:0]       wanted_q;
	logic [5:0]       rec_size_q;
	logic [2:0]       phase_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       sum_q;
	logic [7:0]       msg_q;
	logic [31:0]      time_q;
	logic             wbank_q;
	logic [1:0]       busy_q;

	logic             take;
	logic [7:0]       b;
	logic [7:0]       sum_add;
	logic [CNT_W-1:0] cnt_inc;
	logic             frame_ok;
	logic [CNT_W-1:0] emit_n;
	logic             emit;
	logic [1:0]       busy_d;

	assign cfg_ready = 1'b1;

	// stall payload bytes until the bank being filled is free again
	assign full = (phase_q == PH_DATA) && busy_q[wbank_q];
	assign take = push && !full;
	assign b = item.rx_byte;
	assign sum_add = sum_q + b;
	assign cnt_inc = cnt_q + CNT_W'(1);

	assign frame_ok = (sum_q == b) && (msg_q == wanted_q) &&
		(6'(len_q) >= rec_size_q);
	assign emit_n = (rec_size_q > 6'(MAX_CNT)) ? MAX_CNT : CNT_W'(rec_size_q);
	assign emit = take && (phase_q == PH_SUM) && frame_ok && (emit_n != '0);

	assign wr.en   = take && (phase_q == PH_DATA);
	assign wr.addr = {wbank_q, cnt_q[ADDR_W-1:0]};
	assign wr.data = b;

	assign cmd_push       = emit;
	assign cmd.bank       = wbank_q;
	assign cmd.frame_time = time_q;
	assign cmd.count      = emit_n;

	always_comb begin
		busy_d = busy_q;
		if (rel.valid) begin
			busy_d[rel.bank] = 1'b0;
		end
		if (emit) begin
			busy_d[wbank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q   <= 8'd239;
			wanted_q   <= 8'd81;
			rec_size_q <= 6'd20;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HEADER_BYTE: header_q   <= cfg_data;
				REG_WANTED_MSG:  wanted_q   <= cfg_data;
				REG_RECORD_SIZE: rec_size_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			len_q   <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
			msg_q   <= '0;
			time_q  <= '0;
			wbank_q <= 1'b0;
			busy_q  <= '0;
		end else begin
			busy_q <= busy_d;
			if (emit) begin
				wbank_q <= !wbank_q;
			end
			if (take) begin
				unique case (phase_q)
					PH_HUNT: begin
						if (b == header_q) begin
							time_q  <= item.now_us;
							sum_q   <= b;
							phase_q <= PH_DEV;
						end
					end
					PH_DEV, PH_SYS, PH_SEQ: begin
						sum_q   <= sum_add;
						phase_q <= phase_q + 3'd1;
					end
					PH_MSG: begin
						msg_q   <= b;
						sum_q   <= sum_add;
						phase_q <= PH_SEQ;
					end
					PH_LEN: begin
						sum_q <= sum_add;
						cnt_q <= '0;
						len_q <= CNT_W'(b);
						if (b == 8'd0) begin
							phase_q <= PH_SUM;
						end else if (b > 8'(MAX_PAYLOAD)) begin
							// oversize: drop the frame and hunt again
							phase_q <= PH_HUNT;
							len_q   <= '0;
						end else begin
							phase_q <= PH_DATA;
						end
					end
					PH_DATA: begin
						sum_q <= sum_add;
						if (cnt_inc >= len_q) begin
							cnt_q   <= '0;
							phase_q <= PH_SUM;
						end else begin
							cnt_q <= cnt_inc;
						end
					end
					PH_SUM: begin
						phase_q <= PH_HUNT;
						len_q   <= '0;
						cnt_q   <= '0;
					end
				endcase
			end
		end
	end

endmodule

[rtl/sfp_cmd_queue.sv]
// Two-entry queue of accepted-frame commands between front and back.
module sfp_cmd_queue import sfp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_en,
	input  sfp_cmd_t wr_cmd,
	input  logic     rd_en,
	output logic     empty,
	output sfp_cmd_t rd_cmd
);

	localparam int QAW = $clog2(CMDQ_DEPTH);

	sfp_cmd_t         slot_q [CMDQ_DEPTH];
	logic [QAW-1:0]   wp_q;
	logic [QAW-1:0]   rp_q;
	logic [QAW:0]     cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign empty  = (cnt_q == '0);
	assign rd_cmd = slot_q[rp_q];
	assign do_wr  = wr_en && (cnt_q != (QAW+1)'(CMDQ_DEPTH));
	assign do_rd  = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wp_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + QAW'(1);
			end
			if (do_rd) begin
				rp_q <= rp_q + QAW'(1);
			end
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + (QAW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QAW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/sfp_back.sv]
// Back end: two-bank payload buffer, record read-out and result queue.
module sfp_back import sfp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  sfp_wr_t  wr,
	input  logic     cmd_empty,
	input  sfp_cmd_t cmd,
	output logic     cmd_pop,
	output sfp_rel_t rel,
	output logic     empty,
	input  logic     pop,
	output sfp_out_t result
);

	logic [7:0]       mem [2**BUF_AW];
	logic [7:0]       rdata_q;

	logic             act_q;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] n_q;
	logic [31:0]      time_q;
	logic             bank_q;

	logic             rd_v_s1;
	logic [4:0]       idx_s1;
	logic             last_s1;
	logic [31:0]      time_s1;

	sfp_out_t         fifo_q [OUT_DEPTH];
	logic [OUT_AW-1:0] wp_q;
	logic [OUT_AW-1:0] rp_q;
	logic [OUT_AW:0]  ocnt_q;

	logic             issue;
	logic             is_last;
	logic [CNT_W-1:0] k_inc;
	logic             do_pop;
	sfp_out_t         beat;

	assign k_inc   = k_q + CNT_W'(1);
	assign is_last = (k_inc == n_q);
	// leave room for the read already in flight
	assign issue   = act_q &&
		((ocnt_q + (OUT_AW+1)'(rd_v_s1)) < (OUT_AW+1)'(OUT_DEPTH));
	assign cmd_pop = !act_q && !cmd_empty;

	// bank is free once its last byte has been read
	assign rel.valid = issue && is_last;
	assign rel.bank  = bank_q;

	assign empty  = (ocnt_q == '0);
	assign do_pop = pop && !empty;
	assign result = fifo_q[rp_q];

	assign beat.payload_byte = rdata_q;
	assign beat.byte_index   = idx_s1;
	assign beat.frame_time   = time_s1;
	assign beat.last         = last_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (issue) begin
			rdata_q <= mem[{bank_q, k_q[ADDR_W-1:0]}];
			idx_s1  <= k_q[4:0];
			last_s1 <= is_last;
			time_s1 <= time_q;
		end
		if (rd_v_s1) begin
			fifo_q[wp_q] <= beat;
		end
		if (cmd_pop) begin
			n_q    <= cmd.count;
			time_q <= cmd.frame_time;
			bank_q <= cmd.bank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= 1'b0;
			k_q     <= '0;
			rd_v_s1 <= 1'b0;
			wp_q    <= '0;
			rp_q    <= '0;
			ocnt_q  <= '0;
		end else begin
			rd_v_s1 <= issue;
			if (cmd_pop) begin
				act_q <= 1'b1;
				k_q   <= '0;
			end else if (issue) begin
				k_q <= k_inc;
				if (is_last) begin
					act_q <= 1'b0;
				end
			end
			if (rd_v_s1) begin
				wp_q <= wp_q + OUT_AW'(1);
			end
			if (do_pop) begin
				rp_q <= rp_q + OUT_AW'(1);
			end
			unique case ({rd_v_s1, do_pop})
				2'b10:   ocnt_q <= ocnt_q + (OUT_AW+1)'(1);
				2'b01:   ocnt_q <= ocnt_q - (OUT_AW+1)'(1);
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

endmodule

[rtl/sensor_frame_parser.sv]
// Top level of the sensor frame parser: front end, command queue, back end.
//
//  port group                  direction  beat when
//  push/full/item              in         push && !full
//  empty/pop/result            out        pop && !empty
//  cfg_valid/ready/index/data  in         cfg_valid && cfg_ready
//
// One input byte is taken per cycle; only payload bytes stall (full), and only
// while both buffer banks still hold records waiting for read-out.
// An accepted frame yields its record at up to one byte per cycle, set by the
// single buffer read port and the four-entry result queue.
// Reset is asynchronous and clears all control state and loads register defaults.
// A stalled result side backs up into the read-out, then into payload bytes.
module sensor_frame_parser import sfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  sfp_in_t    item,
	output logic       empty,
	input  logic       pop,
	output sfp_out_t   result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [7:0] cfg_data
);

	sfp_wr_t  wr;
	sfp_cmd_t cmd_in;
	sfp_cmd_t cmd_out;
	sfp_rel_t rel;
	logic     cmd_push;
	logic     cmd_pop;
	logic     cmd_empty;

	sfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.wr        (wr),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.rel       (rel)
	);

	sfp_cmd_queue u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_cmd (cmd_in),
		.rd_en  (cmd_pop),
		.empty  (cmd_empty),
		.rd_cmd (cmd_out)
	);

	sfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.rel       (rel),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
